/* hdl/hevc_config_record_parser_top_defines.svh */
// ----------------------------------------------------------------------------
// hevc_config_record_parser_top_defines
// assertion macros for the configuration record parser
// ----------------------------------------------------------------------------
`ifndef HEVC_CONFIG_RECORD_PARSER_TOP_DEFINES_SVH
`define HEVC_CONFIG_RECORD_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define HCRP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hcrp check failed");
`define HCRP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcrp check failed");
`else
`define HCRP_ASSERT(lbl, clk, rst, prop)
`define HCRP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif

`endif

/* hdl/hcrp_pkg.sv */
// ----------------------------------------------------------------------------
// hcrp_pkg
// types and constants of the configuration record parser
// ----------------------------------------------------------------------------
package hcrp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_CNT_HI,
    PH_CNT_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_FIELD   = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_CORRUPT = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    FLD_VERSION         = 5'd0,
    FLD_PROFILE_SPACE   = 5'd1,
    FLD_TIER            = 5'd2,
    FLD_PROFILE_IDC     = 5'd3,
    FLD_COMPAT_FLAGS    = 5'd4,
    FLD_CONSTRAINT      = 5'd5,
    FLD_LEVEL           = 5'd6,
    FLD_MIN_SEG         = 5'd7,
    FLD_PARALLELISM     = 5'd8,
    FLD_CHROMA_FORMAT   = 5'd9,
    FLD_LUMA_DEPTH      = 5'd10,
    FLD_CHROMA_DEPTH    = 5'd11,
    FLD_AVG_FRAME_RATE  = 5'd12,
    FLD_CONST_RATE      = 5'd13,
    FLD_TEMPORAL_LAYERS = 5'd14,
    FLD_TID_NESTED      = 5'd15,
    FLD_LENGTH_SIZE     = 5'd16
  } field_t;

  localparam int HDR_BYTES = 23;
  localparam logic [4:0] HDR_LAST = 5'(HDR_BYTES - 1);

  localparam int MAX_RES   = 5;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W = $clog2(MAX_RES);

  typedef logic [RES_CNT_W-1:0] rcnt_t;
  typedef logic [RES_IDX_W-1:0] ridx_t;

  localparam logic [5:0] TYPE_MASK = 6'h3f;
  localparam logic [5:0] NAL_VPS   = 6'd32;
  localparam logic [5:0] NAL_SPS   = 6'd33;
  localparam logic [5:0] NAL_PPS   = 6'd34;

  typedef struct packed {
    kind_t       kind;
    field_t      field_id;
    logic [47:0] field_value;
    logic [1:0]  bucket;
    logic [7:0]  nal_byte;
    logic        nal_last;
  } res_t;

endpackage

/* hdl/hevc_config_record_parser_top.sv */
// a beat's results go into the result burst register, then one at a time into the output register
// throughput: one beat per cycle while each beat gives at most one result and the output does not stall
// a beat giving more than one result (up to five on header bytes) holds the input
// until its last result moves to the output register; result_ready low stalls that move
// reset: synchronous, clears the parser state, the burst count and the result valid
// ----------------------------------------------------------------------------
// hevc_config_record_parser_top
// byte-wide parser of an hevc decoder configuration record: header fields,
// parameter set payload bytes, empty, done and corrupt marks
// ----------------------------------------------------------------------------
`include "hevc_config_record_parser_top_defines.svh"

module hevc_config_record_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        record_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [4:0]  field_id,
  output logic [47:0] field_value,
  output logic [1:0]  bucket,
  output logic [7:0]  nal_byte,
  output logic        nal_last,
  output logic        run_last
);

  // parser state
  hcrp_pkg::phase_t phase, phase_next;
  logic [4:0]  header_pos, header_pos_next;
  logic [47:0] field_accum, field_accum_next;
  logic [7:0]  arrays_left, arrays_left_next;
  logic [15:0] nalus_left, nalus_left_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [1:0]  current_bucket, current_bucket_next;
  logic        keep_payload, keep_payload_next;

  // result burst and output register
  hcrp_pkg::res_t  list_next [hcrp_pkg::MAX_RES];
  hcrp_pkg::rcnt_t list_cnt;
  hcrp_pkg::res_t  burst [hcrp_pkg::MAX_RES];
  hcrp_pkg::rcnt_t burst_cnt;
  hcrp_pkg::ridx_t burst_pos;
  hcrp_pkg::res_t  res_q;
  logic            run_last_q;

  logic        accept, load_out, last_move;
  logic [47:0] acc;
  logic [5:0]  nal_type;
  logic [15:0] cnt_word, len_word, bytes_dec;
  logic        last_array, last_nal;

  function automatic hcrp_pkg::res_t mk(hcrp_pkg::kind_t k, hcrp_pkg::field_t id,
                                        logic [47:0] v, logic [1:0] bk,
                                        logic [7:0] by, logic l);
    hcrp_pkg::res_t r;
    r.kind        = k;
    r.field_id    = id;
    r.field_value = v;
    r.bucket      = bk;
    r.nal_byte    = by;
    r.nal_last    = l;
    return r;
  endfunction

  function automatic hcrp_pkg::res_t fld(hcrp_pkg::field_t id, logic [47:0] v);
    return mk(hcrp_pkg::KIND_FIELD, id, v, 2'd0, 8'd0, 1'b0);
  endfunction

  assign acc        = {field_accum[39:0], data_byte};
  assign nal_type   = data_byte[5:0] & hcrp_pkg::TYPE_MASK;
  assign cnt_word   = {nalus_left[15:8], data_byte};
  assign len_word   = {bytes_left[15:8], data_byte};
  assign bytes_dec  = bytes_left - 16'd1;
  assign last_array = (arrays_left == 8'd1);
  assign last_nal   = (nalus_left == 16'd1);

  // next state
  always_comb begin
    phase_next          = phase;
    header_pos_next     = header_pos;
    field_accum_next    = field_accum;
    arrays_left_next    = arrays_left;
    nalus_left_next     = nalus_left;
    bytes_left_next     = bytes_left;
    current_bucket_next = current_bucket;
    keep_payload_next   = keep_payload;
    case (phase)
      hcrp_pkg::PH_HEADER: begin
        case (header_pos)
          5'd2, 5'd6, 5'd19: field_accum_next = 48'(data_byte);
          5'd3, 5'd4, 5'd7, 5'd8, 5'd9, 5'd10: field_accum_next = acc;
          5'd5, 5'd11, 5'd14, 5'd20: field_accum_next = '0;
          5'd13: field_accum_next = 48'(data_byte[3:0]);
          default: ;
        endcase
        if (header_pos == hcrp_pkg::HDR_LAST) begin
          arrays_left_next = data_byte;
          phase_next = (data_byte == 8'd0) ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_TYPE;
        end else begin
          header_pos_next = header_pos + 5'd1;
        end
      end
      hcrp_pkg::PH_TYPE: begin
        if (nal_type == hcrp_pkg::NAL_VPS || nal_type == hcrp_pkg::NAL_SPS ||
            nal_type == hcrp_pkg::NAL_PPS) begin
          keep_payload_next   = 1'b1;
          current_bucket_next = 2'(nal_type - hcrp_pkg::NAL_VPS);
        end else begin
          keep_payload_next   = 1'b0;
          current_bucket_next = 2'd0;
        end
        phase_next = hcrp_pkg::PH_CNT_HI;
      end
      hcrp_pkg::PH_CNT_HI: begin
        nalus_left_next = {data_byte, 8'h00};
        phase_next      = hcrp_pkg::PH_CNT_LO;
      end
      hcrp_pkg::PH_CNT_LO: begin
        nalus_left_next = cnt_word;
        if (cnt_word == 16'd0) begin
          arrays_left_next = arrays_left - 8'd1;
          phase_next = last_array ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_TYPE;
        end else begin
          phase_next = hcrp_pkg::PH_LEN_HI;
        end
      end
      hcrp_pkg::PH_LEN_HI: begin
        bytes_left_next = {data_byte, 8'h00};
        phase_next      = hcrp_pkg::PH_LEN_LO;
      end
      hcrp_pkg::PH_LEN_LO: begin
        bytes_left_next = len_word;
        if (len_word == 16'd0) begin
          nalus_left_next = nalus_left - 16'd1;
          if (last_nal) begin
            arrays_left_next = arrays_left - 8'd1;
            phase_next = last_array ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_TYPE;
          end else begin
            phase_next = hcrp_pkg::PH_LEN_HI;
          end
        end else begin
          phase_next = hcrp_pkg::PH_PAYLOAD;
        end
      end
      hcrp_pkg::PH_PAYLOAD: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == 16'd0) begin
          nalus_left_next = nalus_left - 16'd1;
          if (last_nal) begin
            arrays_left_next = arrays_left - 8'd1;
            phase_next = last_array ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_TYPE;
          end else begin
            phase_next = hcrp_pkg::PH_LEN_HI;
          end
        end
      end
      default: ;
    endcase
    if (record_end) begin
      phase_next          = hcrp_pkg::PH_HEADER;
      header_pos_next     = '0;
      field_accum_next    = '0;
      arrays_left_next    = '0;
      nalus_left_next     = '0;
      bytes_left_next     = '0;
      current_bucket_next = '0;
      keep_payload_next   = 1'b0;
    end
  end

  // results of one beat
  always_comb begin
    hcrp_pkg::rcnt_t n;
    n = '0;
    for (int i = 0; i < hcrp_pkg::MAX_RES; i++) begin
      list_next[i] = '0;
    end
    case (phase)
      hcrp_pkg::PH_HEADER: begin
        case (header_pos)
          5'd0: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] = fld(hcrp_pkg::FLD_VERSION, 48'(data_byte));
            n = n + 1'b1;
          end
          5'd1: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_PROFILE_SPACE, 48'(data_byte[7:6]));
            n = n + 1'b1;
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] = fld(hcrp_pkg::FLD_TIER, 48'(data_byte[5]));
            n = n + 1'b1;
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_PROFILE_IDC, 48'(data_byte[4:0]));
            n = n + 1'b1;
          end
          5'd5: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] = fld(hcrp_pkg::FLD_COMPAT_FLAGS, acc);
            n = n + 1'b1;
          end
          5'd11: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] = fld(hcrp_pkg::FLD_CONSTRAINT, acc);
            n = n + 1'b1;
          end
          5'd12: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] = fld(hcrp_pkg::FLD_LEVEL, 48'(data_byte));
            n = n + 1'b1;
          end
          5'd14: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] = fld(hcrp_pkg::FLD_MIN_SEG, acc);
            n = n + 1'b1;
          end
          5'd15: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_PARALLELISM, 48'(data_byte[1:0]));
            n = n + 1'b1;
          end
          5'd16: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_CHROMA_FORMAT, 48'(data_byte[1:0]));
            n = n + 1'b1;
          end
          5'd17: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_LUMA_DEPTH, 48'(data_byte[2:0]));
            n = n + 1'b1;
          end
          5'd18: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_CHROMA_DEPTH, 48'(data_byte[2:0]));
            n = n + 1'b1;
          end
          5'd20: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] = fld(hcrp_pkg::FLD_AVG_FRAME_RATE, acc);
            n = n + 1'b1;
          end
          5'd21: begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_CONST_RATE, 48'(data_byte[7:6]));
            n = n + 1'b1;
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_TEMPORAL_LAYERS, 48'(data_byte[5:3]));
            n = n + 1'b1;
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_TID_NESTED, 48'(data_byte[2]));
            n = n + 1'b1;
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              fld(hcrp_pkg::FLD_LENGTH_SIZE, 48'(data_byte[1:0]));
            n = n + 1'b1;
          end
          default: ;
        endcase
        if (header_pos == hcrp_pkg::HDR_LAST && data_byte == 8'd0) begin
          list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
            mk(hcrp_pkg::KIND_DONE, hcrp_pkg::FLD_VERSION, '0, 2'd0, 8'd0, 1'b0);
          n = n + 1'b1;
        end
      end
      hcrp_pkg::PH_CNT_LO: begin
        if (cnt_word == 16'd0 && last_array) begin
          list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
            mk(hcrp_pkg::KIND_DONE, hcrp_pkg::FLD_VERSION, '0, 2'd0, 8'd0, 1'b0);
          n = n + 1'b1;
        end
      end
      hcrp_pkg::PH_LEN_LO: begin
        if (len_word == 16'd0) begin
          if (keep_payload) begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              mk(hcrp_pkg::KIND_EMPTY, hcrp_pkg::FLD_VERSION, '0, current_bucket, 8'd0, 1'b0);
            n = n + 1'b1;
          end
          if (last_nal && last_array) begin
            list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
              mk(hcrp_pkg::KIND_DONE, hcrp_pkg::FLD_VERSION, '0, 2'd0, 8'd0, 1'b0);
            n = n + 1'b1;
          end
        end
      end
      hcrp_pkg::PH_PAYLOAD: begin
        if (keep_payload) begin
          list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
            mk(hcrp_pkg::KIND_PAYLOAD, hcrp_pkg::FLD_VERSION, '0, current_bucket,
               data_byte, bytes_dec == 16'd0);
          n = n + 1'b1;
        end
        if (bytes_dec == 16'd0 && last_nal && last_array) begin
          list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
            mk(hcrp_pkg::KIND_DONE, hcrp_pkg::FLD_VERSION, '0, 2'd0, 8'd0, 1'b0);
          n = n + 1'b1;
        end
      end
      default: ;
    endcase
    // early end of record
    if (record_end && phase != hcrp_pkg::PH_DONE) begin
      if (!(n != '0 && list_next[n[hcrp_pkg::RES_IDX_W-1:0] - 1'b1].kind == hcrp_pkg::KIND_DONE))
      begin
        list_next[n[hcrp_pkg::RES_IDX_W-1:0]] =
          mk(hcrp_pkg::KIND_CORRUPT, hcrp_pkg::FLD_VERSION, '0, 2'd0, 8'd0, 1'b0);
        n = n + 1'b1;
      end
    end
    list_cnt = n;
  end

  // handshake
  assign load_out   = (burst_cnt != '0) && (!result_valid || result_ready);
  assign last_move  = load_out && (hcrp_pkg::rcnt_t'(burst_pos) + 1'b1 == burst_cnt);
  assign item_ready = (burst_cnt == '0) || last_move;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hcrp_pkg::PH_HEADER;
      header_pos     <= '0;
      field_accum    <= '0;
      arrays_left    <= '0;
      nalus_left     <= '0;
      bytes_left     <= '0;
      current_bucket <= '0;
      keep_payload   <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      header_pos     <= header_pos_next;
      field_accum    <= field_accum_next;
      arrays_left    <= arrays_left_next;
      nalus_left     <= nalus_left_next;
      bytes_left     <= bytes_left_next;
      current_bucket <= current_bucket_next;
      keep_payload   <= keep_payload_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt <= '0;
      burst_pos <= '0;
    end else if (accept) begin
      burst_cnt <= list_cnt;
      burst_pos <= '0;
    end else if (last_move) begin
      burst_cnt <= '0;
      burst_pos <= '0;
    end else if (load_out) begin
      burst_pos <= burst_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < hcrp_pkg::MAX_RES; i++) begin
        burst[i] <= list_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_q      <= burst[burst_pos];
      run_last_q <= (hcrp_pkg::rcnt_t'(burst_pos) + 1'b1 == burst_cnt);
    end
  end

  assign kind        = res_q.kind;
  assign field_id    = res_q.field_id;
  assign field_value = res_q.field_value;
  assign bucket      = res_q.bucket;
  assign nal_byte    = res_q.nal_byte;
  assign nal_last    = res_q.nal_last;
  assign run_last    = run_last_q;

  `HCRP_ASSERT(a_burst_cnt_range, clk, rst, burst_cnt <= hcrp_pkg::rcnt_t'(hcrp_pkg::MAX_RES))
  `HCRP_ASSERT_IMP(a_burst_pos_range, clk, rst, burst_cnt != '0, hcrp_pkg::rcnt_t'(burst_pos) < burst_cnt)
  `HCRP_ASSERT_IMP(a_end_kinds_last, clk, rst, result_valid && (res_q.kind == hcrp_pkg::KIND_DONE || res_q.kind == hcrp_pkg::KIND_CORRUPT), run_last)
  `HCRP_ASSERT_IMP(a_header_complete, clk, rst, phase != hcrp_pkg::PH_HEADER, header_pos == hcrp_pkg::HDR_LAST)
  `HCRP_ASSERT_IMP(a_bucket_cleared, clk, rst, !keep_payload, current_bucket == 2'd0)

endmodule
